### hdl/qpdpl_pkg.sv
// ----------------------------------------------------------------------------
// qpdpl_pkg: shared definitions for the quadrature PD position loop
// Field widths, item kinds, register indexes, reset values and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package qpdpl_pkg;

	localparam int COUNT_BITS_DEFAULT = 32;

	localparam int FUNC_W   = 2;
	localparam int SAMPLE_W = 10;
	localparam int SCALE_W  = 8;
	localparam int GAIN_W   = 20;
	localparam int POS_W    = 32;
	localparam int DUTY_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 48;

	localparam logic [FUNC_W-1:0] FUNC_A_EDGE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_B_EDGE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN       = 2'd2;

	localparam logic [SCALE_W-1:0] TARGET_SCALE_RESET = 8'd51;
	localparam logic [GAIN_W-1:0]  P_GAIN_RESET       = 20'd31291;
	localparam logic [GAIN_W-1:0]  D_GAIN_RESET       = 20'd522;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

	typedef struct packed {
		logic accept;
		logic err_step;
		logic mul_step;
		logic fin_step;
	} cmd_t;

	typedef struct packed {
		logic tick;
	} status_t;

endpackage

### hdl/quadrature_pd_position_loop.sv
// ----------------------------------------------------------------------------
// quadrature_pd_position_loop: encoder counter with a PD position loop
// Input items are encoder edges, control ticks or unused kinds, which keep
// the count; each item gives a result item with the count and held drive.
//
// Input channel s_*: tuser carries the item kind, tdata the channel levels
// and the potentiometer sample. Output channel m_*: tdata carries the
// position count, direction and duty, tuser flags a new drive value.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, the block does not enforce this. An edge
// item's result is loaded into the output register at the accepting edge.
// A control tick steps through error and target, the two gain multiplies,
// then the sum, magnitude and cap. A new item is accepted while no tick
// is in progress and the output register is empty or being taken in the
// same cycle; a stalled receiver holds the result and the block. Reset
// clears the count and the prior error, sets direction to one, duty to
// zero and loads the default scale and gains.
// ----------------------------------------------------------------------------
module quadrature_pd_position_loop #(
	parameter int COUNT_BITS = qpdpl_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [0] level_a, [1] level_b, [11:2] pot_sample, [15:12] zero
	input  logic [qpdpl_pkg::S_TDATA_W-1:0]       s_tdata,
	// [1:0] func
	input  logic [qpdpl_pkg::FUNC_W-1:0]          s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] position_count, [32] direction, [40:33] duty, [47:41] zero
	output logic [qpdpl_pkg::M_TDATA_W-1:0]       m_tdata,
	// [0] drive_updated
	output logic                                  m_tuser,
	input  logic                                  cfg_we,
	input  logic [qpdpl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qpdpl_pkg::CFG_DATA_W-1:0]      cfg_data
);

	qpdpl_pkg::cmd_t               cmd;
	qpdpl_pkg::status_t            status;
	logic [qpdpl_pkg::POS_W-1:0]   position_count;
	logic                          direction;
	logic [qpdpl_pkg::DUTY_W-1:0]  duty;
	logic                          drive_updated;

	qpdpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	qpdpl_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.func           (s_tuser),
		.level_a        (s_tdata[0]),
		.level_b        (s_tdata[1]),
		.pot_sample     (s_tdata[11:2]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.position_count (position_count),
		.direction      (direction),
		.duty           (duty),
		.drive_updated  (drive_updated)
	);

	assign m_tdata = {7'd0, duty, direction, position_count};
	assign m_tuser = drive_updated;

endmodule

### hdl/qpdpl_ctrl.sv
// ----------------------------------------------------------------------------
// qpdpl_ctrl: sequencer of the quadrature PD position loop
// Runs the handshakes and steps the datapath through a control tick.
// ----------------------------------------------------------------------------
module qpdpl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  qpdpl_pkg::status_t status,
	output qpdpl_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       m_tvalid_q;
	logic       slot_free;
	logic       accept;
	logic       write_result;

	assign slot_free    = !m_tvalid_q || m_tready;
	assign s_tready     = (state_q == ST_IDLE) && slot_free;
	assign accept       = s_tvalid && s_tready;
	assign m_tvalid     = m_tvalid_q;

	assign cmd.accept   = accept;
	assign cmd.err_step = (state_q == ST_ERR);
	assign cmd.mul_step = (state_q == ST_MUL);
	assign cmd.fin_step = (state_q == ST_FIN) && slot_free;

	assign write_result = (accept && !status.tick) || cmd.fin_step;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.tick) begin
					state_next = ST_ERR;
				end
			end
			ST_ERR: state_next = ST_MUL;
			ST_MUL: state_next = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_next;
			m_tvalid_q <= (m_tvalid_q && !m_tready) || write_result;
		end
	end

endmodule

### hdl/qpdpl_datapath.sv
// ----------------------------------------------------------------------------
// qpdpl_datapath: counter, control law and result register
// Holds the position count, the configuration, the PD arithmetic and the
// result item that waits on the output channel.
// ----------------------------------------------------------------------------
module qpdpl_datapath #(
	parameter int COUNT_BITS = qpdpl_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qpdpl_pkg::cmd_t                     cmd,
	output qpdpl_pkg::status_t                  status,
	input  logic [qpdpl_pkg::FUNC_W-1:0]        func,
	input  logic                                level_a,
	input  logic                                level_b,
	input  logic [qpdpl_pkg::SAMPLE_W-1:0]      pot_sample,
	input  logic                                cfg_we,
	input  logic [qpdpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qpdpl_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [qpdpl_pkg::POS_W-1:0]         position_count,
	output logic                                direction,
	output logic [qpdpl_pkg::DUTY_W-1:0]        duty,
	output logic                                drive_updated
);

	logic [qpdpl_pkg::SCALE_W-1:0]  target_scale_q;
	logic [qpdpl_pkg::GAIN_W-1:0]   p_gain_q;
	logic [qpdpl_pkg::GAIN_W-1:0]   d_gain_q;

	logic [COUNT_BITS-1:0]          position_q;
	logic [COUNT_BITS-1:0]          position_next;
	logic signed [31:0]             prior_error_q;
	logic                           held_direction_q;
	logic [qpdpl_pkg::DUTY_W-1:0]   held_duty_q;

	logic [qpdpl_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [31:0]             err_q;
	logic signed [32:0]             diff_q;
	logic signed [52:0]             p_prod_q;
	logic signed [53:0]             d_prod_q;

	logic                           is_edge;
	logic                           count_up;
	logic signed [31:0]             pos_ext;
	logic [17:0]                    target_prod;
	logic [12:0]                    target;
	logic signed [32:0]             err_wide;
	logic signed [31:0]             err_sat;
	logic signed [52:0]             p_prod;
	logic signed [53:0]             d_prod;
	logic signed [54:0]             sum;
	logic [54:0]                    mag;
	logic                           new_direction;
	logic [qpdpl_pkg::DUTY_W-1:0]   new_duty;

	logic [qpdpl_pkg::POS_W-1:0]    res_pos_q;
	logic                           res_dir_q;
	logic [qpdpl_pkg::DUTY_W-1:0]   res_duty_q;
	logic                           res_upd_q;

	assign status.tick = (func == qpdpl_pkg::FUNC_TICK);

	assign is_edge  = (func == qpdpl_pkg::FUNC_A_EDGE) || (func == qpdpl_pkg::FUNC_B_EDGE);
	assign count_up = (level_a != level_b) ^ (func == qpdpl_pkg::FUNC_B_EDGE);

	always_comb begin
		position_next = position_q;
		if (is_edge) begin
			position_next = count_up ? position_q + COUNT_BITS'(1)
			                         : position_q - COUNT_BITS'(1);
		end
	end

	assign pos_ext     = 32'($signed(position_q));
	assign target_prod = 18'(sample_q) * 18'(target_scale_q);
	assign target      = target_prod[17:5];
	assign err_wide    = $signed({20'd0, target}) - 33'(pos_ext);

	always_comb begin
		err_sat = err_wide[31:0];
		if (err_wide[32] != err_wide[31]) begin
			err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	assign p_prod = $signed({1'b0, p_gain_q}) * err_q;
	assign d_prod = $signed({1'b0, d_gain_q}) * diff_q;

	assign sum           = 55'(p_prod_q) + 55'(d_prod_q);
	assign new_direction = !sum[54];
	assign mag           = sum[54] ? 55'(-sum) : 55'(sum);
	assign new_duty      = (|mag[54:24]) ? qpdpl_pkg::DUTY_MAX : mag[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_scale_q   <= qpdpl_pkg::TARGET_SCALE_RESET;
			p_gain_q         <= qpdpl_pkg::P_GAIN_RESET;
			d_gain_q         <= qpdpl_pkg::D_GAIN_RESET;
			position_q       <= '0;
			prior_error_q    <= '0;
			held_direction_q <= 1'b1;
			held_duty_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					qpdpl_pkg::CFG_TARGET_SCALE: target_scale_q <= cfg_data[7:0];
					qpdpl_pkg::CFG_P_GAIN:       p_gain_q       <= cfg_data;
					qpdpl_pkg::CFG_D_GAIN:       d_gain_q       <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				position_q <= position_next;
			end
			if (cmd.fin_step) begin
				held_direction_q <= new_direction;
				held_duty_q      <= new_duty;
				prior_error_q    <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= pot_sample;
		end
		if (cmd.err_step) begin
			err_q  <= err_sat;
			diff_q <= 33'(err_sat) - 33'(prior_error_q);
		end
		if (cmd.mul_step) begin
			p_prod_q <= p_prod;
			d_prod_q <= d_prod;
		end
		if (cmd.accept && !status.tick) begin
			res_pos_q  <= 32'($signed(position_next));
			res_dir_q  <= held_direction_q;
			res_duty_q <= held_duty_q;
			res_upd_q  <= 1'b0;
		end else if (cmd.fin_step) begin
			res_pos_q  <= pos_ext;
			res_dir_q  <= new_direction;
			res_duty_q <= new_duty;
			res_upd_q  <= 1'b1;
		end
	end

	assign position_count = res_pos_q;
	assign direction      = res_dir_q;
	assign duty           = res_duty_q;
	assign drive_updated  = res_upd_q;

endmodule

### sim/quadrature_pd_position_loop_test.sv
// ----------------------------------------------------------------------------
// quadrature_pd_position_loop_test: self-checking bench for the PD loop
// Feeds encoder edges, control ticks and unused items through the input
// stream. A scoreboard mirrors the count, the PD drive and the registers, and
// compares every result item field by field. Several register settings,
// including the extremes, are run; the first four stall both sides at random.
// ----------------------------------------------------------------------------
typedef struct {
	logic [qpdpl_pkg::FUNC_W-1:0]   func;
	logic                           level_a;
	logic                           level_b;
	logic [qpdpl_pkg::SAMPLE_W-1:0] sample;
} encoder_item_t;

typedef struct {
	logic [qpdpl_pkg::POS_W-1:0]  position;
	logic                         direction;
	logic [qpdpl_pkg::DUTY_W-1:0] duty;
	logic                         updated;
} drive_result_t;

class loop_scoreboard;
	logic [qpdpl_pkg::SCALE_W-1:0] target_scale;
	logic [qpdpl_pkg::GAIN_W-1:0]  p_gain;
	logic [qpdpl_pkg::GAIN_W-1:0]  d_gain;
	logic [qpdpl_pkg::POS_W-1:0]   position;
	longint                        prior_error;
	logic                          held_direction;
	logic [qpdpl_pkg::DUTY_W-1:0]  held_duty;
	drive_result_t                 pending_results[$];
	int                            fail_count;
	int                            result_index;

	function new();
		target_scale   = qpdpl_pkg::TARGET_SCALE_RESET;
		p_gain         = qpdpl_pkg::P_GAIN_RESET;
		d_gain         = qpdpl_pkg::D_GAIN_RESET;
		position       = '0;
		prior_error    = 0;
		held_direction = 1'b1;
		held_duty      = '0;
		fail_count     = 0;
		result_index   = 0;
	endfunction

	function void set_register(logic [qpdpl_pkg::CFG_IDX_W-1:0] index,
			logic [qpdpl_pkg::CFG_DATA_W-1:0] value);
		case (index)
			qpdpl_pkg::CFG_TARGET_SCALE: target_scale = value[qpdpl_pkg::SCALE_W-1:0];
			qpdpl_pkg::CFG_P_GAIN:       p_gain = value[qpdpl_pkg::GAIN_W-1:0];
			qpdpl_pkg::CFG_D_GAIN:       d_gain = value[qpdpl_pkg::GAIN_W-1:0];
			default:                     ;
		endcase
	endfunction

	function void note_item(encoder_item_t item);
		drive_result_t result;
		longint        target;
		longint        error;
		longint        drive_sum;
		longint        magnitude;
		logic          step_up;
		result.updated = 1'b0;
		if (item.func == qpdpl_pkg::FUNC_A_EDGE || item.func == qpdpl_pkg::FUNC_B_EDGE) begin
			step_up = (item.level_a != item.level_b) ^ (item.func == qpdpl_pkg::FUNC_B_EDGE);
			position = step_up ? position + 1'b1 : position - 1'b1;
		end else if (item.func == qpdpl_pkg::FUNC_TICK) begin
			target = (longint'(item.sample) * longint'(target_scale)) >>> 5;
			error = target - longint'($signed(position));
			if (error > 64'sd2147483647)
				error = 64'sd2147483647;
			if (error < -64'sd2147483648)
				error = -64'sd2147483648;
			drive_sum = longint'(p_gain) * error
				+ longint'(d_gain) * (error - prior_error);
			held_direction = (drive_sum >= 0);
			magnitude = ((drive_sum < 0) ? -drive_sum : drive_sum) >>> 16;
			held_duty = (magnitude > longint'(qpdpl_pkg::DUTY_MAX)) ? qpdpl_pkg::DUTY_MAX
				: magnitude[qpdpl_pkg::DUTY_W-1:0];
			prior_error = error;
			result.updated = 1'b1;
		end
		result.position  = position;
		result.direction = held_direction;
		result.duty      = held_duty;
		pending_results.push_back(result);
	endfunction

	task report_mismatch(string what);
		$display("MISMATCH at result %0d: %s", result_index, what);
		fail_count++;
	endtask

	task check_result(logic [qpdpl_pkg::M_TDATA_W-1:0] data, logic drive_flag);
		drive_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result item %h with nothing expected", data));
		end else begin
			want = pending_results.pop_front();
			if (data[qpdpl_pkg::POS_W-1:0] !== want.position)
				report_mismatch($sformatf("position %h, expected %h",
					data[qpdpl_pkg::POS_W-1:0], want.position));
			if (data[qpdpl_pkg::POS_W] !== want.direction)
				report_mismatch($sformatf("direction %b, expected %b",
					data[qpdpl_pkg::POS_W], want.direction));
			if (data[qpdpl_pkg::POS_W+1 +: qpdpl_pkg::DUTY_W] !== want.duty)
				report_mismatch($sformatf("duty %0d, expected %0d",
					data[qpdpl_pkg::POS_W+1 +: qpdpl_pkg::DUTY_W], want.duty));
			if (drive_flag !== want.updated)
				report_mismatch($sformatf("drive_updated %b, expected %b",
					drive_flag, want.updated));
		end
		result_index++;
	endtask
endclass

module quadrature_pd_position_loop_test;

	localparam logic [qpdpl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 1000;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [qpdpl_pkg::S_TDATA_W-1:0]    s_tdata;
	logic [qpdpl_pkg::FUNC_W-1:0]       s_tuser;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [qpdpl_pkg::M_TDATA_W-1:0]    m_tdata;
	logic                               m_tuser;
	logic                               cfg_we;
	logic [qpdpl_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [qpdpl_pkg::CFG_DATA_W-1:0]   cfg_data;

	loop_scoreboard sb;
	int   send_idle_pct = 9;
	int   recv_idle_pct = 54;
	int   quiet_cycles = 0;
	logic drift_up = 1'b1;

	quadrature_pd_position_loop uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(encoder_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= item.func;
		s_tdata  <= {{(qpdpl_pkg::S_TDATA_W-qpdpl_pkg::SAMPLE_W-2){1'b0}}, item.sample,
			item.level_b, item.level_a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(item);
	endtask

	task automatic send_fields(logic [qpdpl_pkg::FUNC_W-1:0] func, logic a, logic b,
			logic [qpdpl_pkg::SAMPLE_W-1:0] sample);
		encoder_item_t item;
		item.func    = func;
		item.level_a = a;
		item.level_b = b;
		item.sample  = sample;
		send_item(item);
	endtask

	function automatic encoder_item_t random_item();
		encoder_item_t item;
		int            pick = $urandom_range(99);
		logic          step_up;
		item.level_a = 1'($urandom_range(1));
		item.level_b = 1'($urandom_range(1));
		case ($urandom_range(9))
			0:       item.sample = '0;
			1:       item.sample = '1;
			default: item.sample = qpdpl_pkg::SAMPLE_W'($urandom_range(1023));
		endcase
		if (pick < 4) begin
			item.func = FUNC_UNUSED;
		end else if (pick < 30) begin
			item.func = qpdpl_pkg::FUNC_TICK;
		end else begin
			item.func = $urandom_range(1) ? qpdpl_pkg::FUNC_B_EDGE : qpdpl_pkg::FUNC_A_EDGE;
			if ($urandom_range(63) == 0)
				drift_up = ~drift_up;
			step_up = ($urandom_range(9) < 8) ? drift_up : ~drift_up;
			item.level_b = item.level_a ^ step_up ^ (item.func == qpdpl_pkg::FUNC_B_EDGE);
		end
		return item;
	endfunction

	task automatic run_random(int count);
		repeat (count)
			send_item(random_item());
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_register(logic [qpdpl_pkg::CFG_IDX_W-1:0] index,
			logic [qpdpl_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		sb.set_register(index, value);
	endtask

	task automatic write_config(logic [qpdpl_pkg::SCALE_W-1:0] scale,
			logic [qpdpl_pkg::GAIN_W-1:0] p, logic [qpdpl_pkg::GAIN_W-1:0] d);
		write_register(qpdpl_pkg::CFG_TARGET_SCALE, qpdpl_pkg::CFG_DATA_W'(scale));
		write_register(qpdpl_pkg::CFG_P_GAIN, p);
		write_register(qpdpl_pkg::CFG_D_GAIN, d);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= qpdpl_pkg::FUNC_A_EDGE;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= qpdpl_pkg::CFG_TARGET_SCALE;
		cfg_data  <= '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(qpdpl_pkg::FUNC_TICK, 1'b0, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b1, 1'b1, 10'd1023);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b0, 1'b1, 10'd1023);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b1, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_A_EDGE, 1'b0, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_A_EDGE, 1'b0, 1'b1, 10'd1023);
		send_fields(qpdpl_pkg::FUNC_A_EDGE, 1'b1, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_A_EDGE, 1'b1, 1'b1, 10'd1023);
		send_fields(qpdpl_pkg::FUNC_B_EDGE, 1'b0, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_B_EDGE, 1'b0, 1'b1, 10'd1023);
		send_fields(qpdpl_pkg::FUNC_B_EDGE, 1'b1, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_B_EDGE, 1'b1, 1'b1, 10'd1023);
		send_fields(FUNC_UNUSED, 1'b1, 1'b1, 10'd1023);
		repeat (5)
			send_fields(qpdpl_pkg::FUNC_A_EDGE, 1'b0, 1'b1, 10'd0);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b0, 1'b0, 10'd0);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b0, 1'b0, 10'd5);
		send_fields(qpdpl_pkg::FUNC_TICK, 1'b1, 1'b1, 10'd1);
		send_fields(FUNC_UNUSED, 1'b0, 1'b0, 10'd0);
		run_random(230);

		settle();
		write_config(8'd255, 20'hFFFFF, 20'hFFFFF);
		run_random(240);

		settle();
		send_idle_pct = 54;
		recv_idle_pct = 9;
		write_config(8'd0, 20'd0, 20'd0);
		run_random(240);

		settle();
		write_config(qpdpl_pkg::SCALE_W'($urandom_range(255)),
			qpdpl_pkg::GAIN_W'($urandom_range(1048575)),
			qpdpl_pkg::GAIN_W'($urandom_range(1048575)));
		run_random(240);

		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_config(8'd1, 20'd1, 20'hFFFFF);
		run_random(240);

		settle();
		write_config(qpdpl_pkg::TARGET_SCALE_RESET, qpdpl_pkg::P_GAIN_RESET,
			qpdpl_pkg::D_GAIN_RESET);
		run_random(240);

		settle();
		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
